### design/aprm_pkg.sv
// ----------------------------------------------------------------------------
// aprm_pkg: shared types and constants of the audio peak / RMS / clip meter
// Widths, register codes, the block record handed from front to back, and
// the state encodings of both control machines.
// ----------------------------------------------------------------------------
`default_nettype none

package aprm_pkg;

  // Channel layout: lane 0 is left, the last lane is right
  localparam int CHANNELS = 2;
  localparam int RIGHT_CH = (CHANNELS > 1) ? 1 : 0;

  // Sample path
  localparam int SAMPLE_W = 24;
  localparam int MAG_W    = 24;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 58;

  // Block length
  localparam int MAX_BLOCK = 4096;
  localparam int CNT_W     = 13;

  // Mean square: full scale 1.0 = 2^32, one spare bit for exactly 1.0
  localparam int MS_SHIFT   = 14;
  localparam int MS_W       = 33;
  localparam int DIV_TOP    = MS_SHIFT + MS_W;
  localparam int DIV_STEP_W = $clog2(MS_W);

  // Square root
  localparam int ROOT_W      = 24;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int ROOT_REM_W  = ROOT_W + 2;
  localparam int ROOT_STEP_W = $clog2(ROOT_W);

  // Configuration fields
  localparam int GAIN_W     = 16;
  localparam int COEF_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int THR_W      = 24;
  localparam int HOLD_W     = 20;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0] DECAY_GAIN_RST = GAIN_W'(64880);
  localparam logic [COEF_W-1:0] RMS_COEF_RST   = COEF_W'(3000);
  localparam logic [THR_W-1:0]  CLIP_THR_RST   = THR_W'(8388608);
  localparam logic [HOLD_W-1:0] CLIP_HOLD_RST  = HOLD_W'(48000);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [MS_W-1:0]  SMS_MAX = MS_W'(1) << (MS_W - 1);

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DECAY_GAIN = 3'd0,
    CFG_RMS_COEF   = 3'd1,
    CFG_CLIP_THR   = 3'd2,
    CFG_CLIP_HOLD  = 3'd3,
    CFG_MONO       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] decay_gain;
    logic [COEF_W-1:0] rms_coef;
    logic [THR_W-1:0]  clip_thr;
    logic [HOLD_W-1:0] clip_hold;
    logic              mono;
  } cfg_t;

  // One closed block, as handed from the front to the back
  typedef struct packed {
    logic [CHANNELS-1:0][MAG_W-1:0] peak;
    logic [CHANNELS-1:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]               count;
  } blk_rec_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SQUARE,
    FE_ACCUM
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_DIVIDE,
    BE_UPDATE,
    BE_SCALE,
    BE_SMOOTH,
    BE_ROOT,
    BE_EMIT
  } be_state_t;

endpackage

`default_nettype wire

### design/aprm_stream_if.sv
// ----------------------------------------------------------------------------
// aprm_stream_if: valid/ready channels of the meter
// aprm_in_if carries one stereo sample pair, aprm_out_if one meter reading.
// ----------------------------------------------------------------------------
`default_nettype none

interface aprm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [aprm_pkg::SAMPLE_W-1:0] sample_left;
  logic signed [aprm_pkg::SAMPLE_W-1:0] sample_right;
  logic                                block_end;

  modport source (output valid, sample_left, sample_right, block_end, input ready);
  modport sink   (input valid, sample_left, sample_right, block_end, output ready);
endinterface

interface aprm_out_if;
  logic                        valid;
  logic                        ready;
  logic [aprm_pkg::MAG_W-1:0]  peak_left;
  logic [aprm_pkg::MAG_W-1:0]  peak_right;
  logic [aprm_pkg::ROOT_W-1:0] rms_left;
  logic [aprm_pkg::ROOT_W-1:0] rms_right;
  logic                        clip_active;

  modport source (output valid, peak_left, peak_right, rms_left, rms_right, clip_active,
                  input ready);
  modport sink   (input valid, peak_left, peak_right, rms_left, rms_right, clip_active,
                  output ready);
endinterface

`default_nettype wire

### design/aprm_front.sv
// ----------------------------------------------------------------------------
// aprm_front: sample intake and block accumulation
// Takes one sample pair, squares the magnitudes, folds them into the block
// peak and saturating sum of squares, and pushes a block record on close.
// ----------------------------------------------------------------------------
`default_nettype none

module aprm_front (
  input  logic               clk,
  input  logic               rst_n,
  aprm_in_if.sink            in_bus,
  input  logic               mono_i,
  output logic               push_o,
  output aprm_pkg::blk_rec_t push_rec_o,
  input  logic               full_i
);

  aprm_pkg::fe_state_t state_r, state_nxt;

  logic [aprm_pkg::MAG_W-1:0] mag_r  [aprm_pkg::CHANNELS];
  logic [aprm_pkg::SQ_W-1:0]  sq_r   [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MAG_W-1:0] peak_r [aprm_pkg::CHANNELS];
  logic [aprm_pkg::SUM_W-1:0] sum_r  [aprm_pkg::CHANNELS];
  logic [aprm_pkg::CNT_W-1:0] cnt_r;
  logic                       end_r;

  logic [aprm_pkg::MAG_W-1:0] peak_nxt [aprm_pkg::CHANNELS];
  logic [aprm_pkg::SUM_W-1:0] sum_nxt  [aprm_pkg::CHANNELS];
  logic [aprm_pkg::SUM_W:0]   sum_ext  [aprm_pkg::CHANNELS];
  logic [aprm_pkg::CNT_W-1:0] cnt_inc;
  logic                       close;
  logic                       ready_int;
  logic                       accept;
  logic                       acc_en;

  function automatic logic [aprm_pkg::MAG_W-1:0] mag_of(
    input logic [aprm_pkg::SAMPLE_W-1:0] raw
  );
    logic [aprm_pkg::SAMPLE_W-1:0] neg;
    neg = ~raw + 1'b1;
    return aprm_pkg::MAG_W'(raw[aprm_pkg::SAMPLE_W-1] ? neg : raw);
  endfunction

  // Fold the current squares into the open block
  always_comb begin
    cnt_inc = cnt_r + 1'b1;
    close   = end_r || (cnt_inc == aprm_pkg::CNT_W'(aprm_pkg::MAX_BLOCK));
    for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
      peak_nxt[c] = (mag_r[c] > peak_r[c]) ? mag_r[c] : peak_r[c];
      sum_ext[c]  = {1'b0, sum_r[c]} + (aprm_pkg::SUM_W + 1)'(sq_r[c]);
      sum_nxt[c]  = sum_ext[c][aprm_pkg::SUM_W] ? aprm_pkg::SUM_MAX
                                                 : sum_ext[c][aprm_pkg::SUM_W-1:0];
      push_rec_o.peak[c] = peak_nxt[c];
      push_rec_o.sum[c]  = sum_nxt[c];
    end
    push_rec_o.count = cnt_inc;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aprm_pkg::FE_IDLE:   if (in_bus.valid) state_nxt = aprm_pkg::FE_SQUARE;
      aprm_pkg::FE_SQUARE: state_nxt = aprm_pkg::FE_ACCUM;
      aprm_pkg::FE_ACCUM:  if (!(close && full_i)) state_nxt = aprm_pkg::FE_IDLE;
      default:             state_nxt = aprm_pkg::FE_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ready_int = (state_r == aprm_pkg::FE_IDLE);
    acc_en    = (state_r == aprm_pkg::FE_ACCUM) && !(close && full_i);
    push_o    = acc_en && close;
  end

  assign in_bus.ready = ready_int;
  assign accept       = in_bus.valid && ready_int;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aprm_pkg::FE_IDLE;
      cnt_r   <= '0;
      for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
        peak_r[c] <= '0;
        sum_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (acc_en) begin
        cnt_r <= close ? '0 : cnt_inc;
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          peak_r[c] <= close ? '0 : peak_nxt[c];
          sum_r[c]  <= close ? '0 : sum_nxt[c];
        end
      end
    end
  end

  // Capture magnitudes, then square them
  always_ff @(posedge clk) begin
    if (accept) begin
      end_r <= in_bus.block_end;
      for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
        mag_r[c] <= (c == 0 || mono_i) ? mag_of(in_bus.sample_left)
                                       : mag_of(in_bus.sample_right);
      end
    end
    if (state_r == aprm_pkg::FE_SQUARE) begin
      for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
        sq_r[c] <= mag_r[c] * mag_r[c];
      end
    end
  end

  // The open block never reaches the forced close length
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < aprm_pkg::CNT_W'(aprm_pkg::MAX_BLOCK))
    else $error("front block count reached forced close length");

endmodule

`default_nettype wire

### design/aprm_queue.sv
// ----------------------------------------------------------------------------
// aprm_queue: short block-record queue between front and back
// Register-based FIFO; lets the front keep taking samples while the back
// works on an earlier block.
// ----------------------------------------------------------------------------
`default_nettype none

module aprm_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  aprm_pkg::blk_rec_t push_rec_i,
  output logic               full_o,
  input  logic               pop_i,
  output aprm_pkg::blk_rec_t pop_rec_o,
  output logic               empty_o
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  aprm_pkg::blk_rec_t mem [DEPTH];

  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o    = (fill_r == FILL_W'(DEPTH));
  assign empty_o   = (fill_r == '0);
  assign pop_rec_o = mem[rd_ptr_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push_i) wr_ptr_r <= ptr_adv(wr_ptr_r);
      if (pop_i)  rd_ptr_r <= ptr_adv(rd_ptr_r);
      if (push_i && !pop_i)      fill_r <= fill_r + 1'b1;
      else if (pop_i && !push_i) fill_r <= fill_r - 1'b1;
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (push_i) mem[wr_ptr_r] <= push_rec_i;
  end

  assert property (@(posedge clk) disable iff (!rst_n) push_i |-> !full_o)
    else $error("block record pushed into a full queue");

  assert property (@(posedge clk) disable iff (!rst_n) pop_i |-> !empty_o)
    else $error("block record popped from an empty queue");

endmodule

`default_nettype wire

### design/aprm_back.sv
// ----------------------------------------------------------------------------
// aprm_back: block-end processing
// Per channel: restoring divide of the square sum by the block length, peak
// hold and release, one-pole mean-square smoothing, bit-pair square root.
// Also keeps the clip hold countdown and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aprm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  aprm_pkg::cfg_t     cfg_i,
  input  logic               empty_i,
  input  aprm_pkg::blk_rec_t rec_i,
  output logic               pop_o,
  aprm_out_if.source         out_bus
);

  localparam int PROD_W  = aprm_pkg::MS_W + aprm_pkg::COEF_W;
  localparam int DECAY_W = aprm_pkg::MAG_W + aprm_pkg::GAIN_W;

  aprm_pkg::be_state_t state_r, state_nxt;

  // Working registers
  logic [aprm_pkg::MAG_W-1:0]       bpk_r     [aprm_pkg::CHANNELS];
  logic [aprm_pkg::CNT_W-1:0]       div_n_r;
  logic [aprm_pkg::CNT_W-1:0]       div_rem_r [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MS_W-1:0]        div_quo_r [aprm_pkg::CHANNELS];
  logic [aprm_pkg::DIV_STEP_W-1:0]  div_step_r;
  logic [aprm_pkg::MS_W-1:0]        diff_r    [aprm_pkg::CHANNELS];
  logic                             up_r      [aprm_pkg::CHANNELS];
  logic [PROD_W-1:0]                prod_r    [aprm_pkg::CHANNELS];
  logic [aprm_pkg::RAD_W-1:0]       rad_r     [aprm_pkg::CHANNELS];
  logic [aprm_pkg::ROOT_REM_W-1:0]  rrem_r    [aprm_pkg::CHANNELS];
  logic [aprm_pkg::ROOT_W-1:0]      root_r    [aprm_pkg::CHANNELS];
  logic [aprm_pkg::ROOT_STEP_W-1:0] root_step_r;

  // Meter state
  logic [aprm_pkg::MAG_W-1:0]  held_r [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MS_W-1:0]   sms_r  [aprm_pkg::CHANNELS];
  logic [aprm_pkg::HOLD_W-1:0] clip_cd_r;

  // Output register
  logic                        out_valid_r;
  logic [aprm_pkg::MAG_W-1:0]  pk_out_r  [aprm_pkg::CHANNELS];
  logic [aprm_pkg::ROOT_W-1:0] rms_out_r [aprm_pkg::CHANNELS];
  logic                        clip_out_r;

  // Lane arithmetic
  logic [aprm_pkg::CNT_W:0]        div_trial [aprm_pkg::CHANNELS];
  logic [aprm_pkg::CNT_W:0]        div_sub   [aprm_pkg::CHANNELS];
  logic                            div_ge    [aprm_pkg::CHANNELS];
  logic                            mean_ge   [aprm_pkg::CHANNELS];
  logic [DECAY_W-1:0]              decayed   [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MS_W-1:0]       sm_step   [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MS_W:0]         sms_up    [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MS_W-1:0]       sms_new   [aprm_pkg::CHANNELS];
  logic [aprm_pkg::ROOT_REM_W-1:0] root_rem2 [aprm_pkg::CHANNELS];
  logic [aprm_pkg::ROOT_REM_W-1:0] root_try  [aprm_pkg::CHANNELS];
  logic                            root_ge   [aprm_pkg::CHANNELS];
  logic                            clipped;
  logic [aprm_pkg::HOLD_W-1:0]     n_ext;
  logic                            out_free;
  logic                            emit_load;

  // Per-lane datapath
  always_comb begin
    clipped = 1'b0;
    for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
      div_trial[c] = {div_rem_r[c], div_quo_r[c][aprm_pkg::MS_W-1]};
      div_sub[c]   = div_trial[c] - {1'b0, div_n_r};
      div_ge[c]    = div_trial[c] >= {1'b0, div_n_r};

      mean_ge[c] = div_quo_r[c] >= sms_r[c];
      decayed[c] = held_r[c] * cfg_i.decay_gain;
      if (bpk_r[c] >= cfg_i.clip_thr) clipped = 1'b1;

      sm_step[c] = prod_r[c][aprm_pkg::MS_W+aprm_pkg::FRAC_W-1:aprm_pkg::FRAC_W];
      sms_up[c]  = {1'b0, sms_r[c]} + {1'b0, sm_step[c]};
      if (up_r[c]) begin
        sms_new[c] = (sms_up[c] > {1'b0, aprm_pkg::SMS_MAX}) ? aprm_pkg::SMS_MAX
                                                           : sms_up[c][aprm_pkg::MS_W-1:0];
      end else begin
        sms_new[c] = sms_r[c] - sm_step[c];
      end

      root_rem2[c] = {rrem_r[c][aprm_pkg::ROOT_REM_W-3:0],
                      rad_r[c][aprm_pkg::RAD_W-1 -: 2]};
      root_try[c]  = {root_r[c], 2'b01};
      root_ge[c]   = root_rem2[c] >= root_try[c];
    end
    n_ext = aprm_pkg::HOLD_W'(div_n_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aprm_pkg::BE_IDLE:   if (!empty_i) state_nxt = aprm_pkg::BE_DIVIDE;
      aprm_pkg::BE_DIVIDE: if (div_step_r == '0) state_nxt = aprm_pkg::BE_UPDATE;
      aprm_pkg::BE_UPDATE: state_nxt = aprm_pkg::BE_SCALE;
      aprm_pkg::BE_SCALE:  state_nxt = aprm_pkg::BE_SMOOTH;
      aprm_pkg::BE_SMOOTH: state_nxt = aprm_pkg::BE_ROOT;
      aprm_pkg::BE_ROOT:   if (root_step_r == '0) state_nxt = aprm_pkg::BE_EMIT;
      aprm_pkg::BE_EMIT:   if (out_free) state_nxt = aprm_pkg::BE_IDLE;
      default:             state_nxt = aprm_pkg::BE_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    out_free  = !out_valid_r || out_bus.ready;
    pop_o     = (state_r == aprm_pkg::BE_IDLE) && !empty_i;
    emit_load = (state_r == aprm_pkg::BE_EMIT) && out_free;
  end

  // Control and meter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aprm_pkg::BE_IDLE;
      clip_cd_r   <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
        held_r[c] <= '0;
        sms_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit_load)          out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
      if (state_r == aprm_pkg::BE_UPDATE) begin
        if (clipped)              clip_cd_r <= cfg_i.clip_hold;
        else if (clip_cd_r > n_ext) clip_cd_r <= clip_cd_r - n_ext;
        else                      clip_cd_r <= '0;
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          held_r[c] <= (bpk_r[c] > held_r[c])
                     ? bpk_r[c]
                     : decayed[c][aprm_pkg::MAG_W+aprm_pkg::FRAC_W-1:aprm_pkg::FRAC_W];
        end
      end
      if (state_r == aprm_pkg::BE_SMOOTH) begin
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) sms_r[c] <= sms_new[c];
      end
    end
  end

  // Working datapath: load, divide, update, scale, smooth, root, emit
  always_ff @(posedge clk) begin
    case (state_r)
      aprm_pkg::BE_IDLE: begin
        div_n_r    <= rec_i.count;
        div_step_r <= aprm_pkg::DIV_STEP_W'(aprm_pkg::MS_W - 1);
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          bpk_r[c]     <= rec_i.peak[c];
          div_rem_r[c] <= aprm_pkg::CNT_W'(rec_i.sum[c][aprm_pkg::SUM_W-1:aprm_pkg::DIV_TOP]);
          div_quo_r[c] <= rec_i.sum[c][aprm_pkg::DIV_TOP-1:aprm_pkg::MS_SHIFT];
        end
      end
      aprm_pkg::BE_DIVIDE: begin
        div_step_r <= div_step_r - 1'b1;
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          div_rem_r[c] <= div_ge[c] ? div_sub[c][aprm_pkg::CNT_W-1:0]
                                    : div_trial[c][aprm_pkg::CNT_W-1:0];
          div_quo_r[c] <= {div_quo_r[c][aprm_pkg::MS_W-2:0], div_ge[c]};
        end
      end
      aprm_pkg::BE_UPDATE: begin
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          up_r[c]   <= mean_ge[c];
          diff_r[c] <= mean_ge[c] ? div_quo_r[c] - sms_r[c] : sms_r[c] - div_quo_r[c];
        end
      end
      aprm_pkg::BE_SCALE: begin
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          prod_r[c] <= diff_r[c] * cfg_i.rms_coef;
        end
      end
      aprm_pkg::BE_SMOOTH: begin
        root_step_r <= aprm_pkg::ROOT_STEP_W'(aprm_pkg::ROOT_W - 1);
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          rad_r[c]  <= aprm_pkg::RAD_W'({sms_new[c], {aprm_pkg::MS_SHIFT{1'b0}}});
          rrem_r[c] <= '0;
          root_r[c] <= '0;
        end
      end
      aprm_pkg::BE_ROOT: begin
        root_step_r <= root_step_r - 1'b1;
        for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
          rad_r[c]  <= rad_r[c] << 2;
          rrem_r[c] <= root_ge[c] ? root_rem2[c] - root_try[c] : root_rem2[c];
          root_r[c] <= {root_r[c][aprm_pkg::ROOT_W-2:0], root_ge[c]};
        end
      end
      default: ;
    endcase
    if (emit_load) begin
      clip_out_r <= (clip_cd_r != '0);
      for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
        pk_out_r[c]  <= held_r[c];
        rms_out_r[c] <= root_r[c];
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.peak_left   = pk_out_r[0];
  assign out_bus.peak_right  = pk_out_r[aprm_pkg::RIGHT_CH];
  assign out_bus.rms_left    = rms_out_r[0];
  assign out_bus.rms_right   = rms_out_r[aprm_pkg::RIGHT_CH];
  assign out_bus.clip_active = clip_out_r;

  // Smoothed mean square never passes full scale
  for (genvar g = 0; g < aprm_pkg::CHANNELS; g++) begin : g_sms_chk
    assert property (@(posedge clk) disable iff (!rst_n) sms_r[g] <= aprm_pkg::SMS_MAX)
      else $error("smoothed mean square above full scale");
  end

endmodule

`default_nettype wire

### design/audio_peak_rms_clip_meter.sv
// Front: each item passes magnitude, square and accumulate before the next is taken,
// and a closing item waits there while the block queue is full. Back: each closed
// block passes the 33-step divider and the 24-step square root, with a 2-entry
// block queue between the two.
// Reset (rst_n, synchronous, active low) clears meters, sums and countdown.
// ----------------------------------------------------------------------------
// audio_peak_rms_clip_meter: stereo peak, RMS and clip meter
// Configuration register file plus the front, block queue and back units.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_peak_rms_clip_meter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  aprm_in_if.sink                            in_bus,
  aprm_out_if.source                         out_bus,
  input  logic                               cfg_we,
  input  logic [aprm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [aprm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  aprm_pkg::cfg_t     cfg_r;
  aprm_pkg::blk_rec_t push_rec;
  aprm_pkg::blk_rec_t pop_rec;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_gain <= aprm_pkg::DECAY_GAIN_RST;
      cfg_r.rms_coef   <= aprm_pkg::RMS_COEF_RST;
      cfg_r.clip_thr   <= aprm_pkg::CLIP_THR_RST;
      cfg_r.clip_hold  <= aprm_pkg::CLIP_HOLD_RST;
      cfg_r.mono       <= 1'b0;
    end else if (cfg_we) begin
      unique case (aprm_pkg::cfg_idx_t'(cfg_addr))
        aprm_pkg::CFG_DECAY_GAIN: cfg_r.decay_gain <= cfg_wdata[aprm_pkg::GAIN_W-1:0];
        aprm_pkg::CFG_RMS_COEF:   cfg_r.rms_coef   <= cfg_wdata[aprm_pkg::COEF_W-1:0];
        aprm_pkg::CFG_CLIP_THR:   cfg_r.clip_thr   <= cfg_wdata[aprm_pkg::THR_W-1:0];
        aprm_pkg::CFG_CLIP_HOLD:  cfg_r.clip_hold  <= cfg_wdata[aprm_pkg::HOLD_W-1:0];
        aprm_pkg::CFG_MONO:       cfg_r.mono       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  aprm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .mono_i     (cfg_r.mono),
    .push_o     (push),
    .push_rec_o (push_rec),
    .full_i     (q_full)
  );

  aprm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .empty_o    (q_empty)
  );

  aprm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg_r),
    .empty_i (q_empty),
    .rec_i   (pop_rec),
    .pop_o   (pop),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

### sim/audio_peak_rms_clip_meter_tb.sv
// ----------------------------------------------------------------------------
// audio_peak_rms_clip_meter_tb: self-checking bench for the level meter
// Drives stereo sample items through the input channel and predicts the
// untyped meter readings from an internal bit-true model of peak hold,
// smoothed mean square, square root and clip hold. A short table of directed
// items comes first, then random blocks under several register settings and
// idle mixes, one output back-pressure stretch and one long full-scale block.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_peak_rms_clip_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int CLOSE_LATENCY = 65;
  localparam int SETTLE_CYCLES = 2 * CLOSE_LATENCY;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 130;
  localparam int RX_HOLD       = 600;
  localparam int FULL_ITEMS    = 64;

  localparam logic signed [aprm_pkg::SAMPLE_W-1:0] S_MIN =
    {1'b1, {(aprm_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [aprm_pkg::SAMPLE_W-1:0] S_MAX =
    {1'b0, {(aprm_pkg::SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic [aprm_pkg::MAG_W-1:0]  peak_l;
    logic [aprm_pkg::MAG_W-1:0]  peak_r;
    logic [aprm_pkg::ROOT_W-1:0] rms_l;
    logic [aprm_pkg::ROOT_W-1:0] rms_r;
    logic                        clip;
  } reading_t;

  typedef struct packed {
    logic signed [aprm_pkg::SAMPLE_W-1:0] left;
    logic signed [aprm_pkg::SAMPLE_W-1:0] right;
    logic                                 last;
    logic                                 typed;
    reading_t                             want;
  } dir_row_t;

  localparam reading_t ZERO_RD = '0;

  // Directed items under reset settings; typed rows carry their reading
  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{24'sd0,       24'sd0,        1'b1, 1'b1, ZERO_RD},  // silent block after reset
    '{24'sd0,       24'sd0,        1'b0, 1'b0, ZERO_RD},  // open without a reading
    '{24'sd0,       24'sd0,        1'b1, 1'b1, ZERO_RD},  // silent two-item block
    '{S_MIN,        S_MAX,         1'b1, 1'b0, ZERO_RD},  // full scale, left clips
    '{24'sd0,       24'sd0,        1'b1, 1'b0, ZERO_RD},  // peak release
    '{S_MAX,        S_MIN,         1'b0, 1'b0, ZERO_RD},
    '{24'sd1,       -24'sd1,       1'b0, 1'b0, ZERO_RD},
    '{-24'sd1,      24'sd1,        1'b1, 1'b0, ZERO_RD},
    '{24'sh400000,  -24'sh400000,  1'b1, 1'b0, ZERO_RD},
    '{24'sd1000,    -24'sd3000,    1'b0, 1'b0, ZERO_RD},
    '{-24'sd5000,   24'sd7000,     1'b0, 1'b0, ZERO_RD},
    '{24'sd9,       24'sd0,        1'b1, 1'b0, ZERO_RD},
    '{24'sd0,       24'sd0,        1'b1, 1'b0, ZERO_RD},
    '{24'sd0,       24'sd0,        1'b1, 1'b0, ZERO_RD},
    '{S_MIN,        S_MIN,         1'b0, 1'b0, ZERO_RD},
    '{S_MIN,        S_MIN,         1'b1, 1'b0, ZERO_RD},
    '{24'sh555555,  24'shAAAAAA,   1'b1, 1'b0, ZERO_RD},
    '{24'sh7FFF00,  -24'sh7FFF00,  1'b1, 1'b0, ZERO_RD},
    '{24'sd0,       24'sd0,        1'b1, 1'b0, ZERO_RD}
  };

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [aprm_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [aprm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  aprm_in_if  sample_ch ();
  aprm_out_if reading_ch ();

  audio_peak_rms_clip_meter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (sample_ch),
    .out_bus   (reading_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Meter model state and its copy of the registers
  aprm_pkg::cfg_t              meter_cfg;
  logic [aprm_pkg::MAG_W-1:0]  held_level  [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MS_W-1:0]   smoothed_ms [aprm_pkg::CHANNELS];
  logic [aprm_pkg::MAG_W-1:0]  open_peak   [aprm_pkg::CHANNELS];
  logic [aprm_pkg::SUM_W-1:0]  open_sq_sum [aprm_pkg::CHANNELS];
  logic [aprm_pkg::CNT_W-1:0]  open_count;
  logic [aprm_pkg::HOLD_W-1:0] clip_countdown_q;

  reading_t pending_readings [$];
  int       mismatches  = 0;
  int       items_sent  = 0;
  int       cycle_count = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       rx_hold_req = 0;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Floor square root, bit by bit
  function automatic logic [aprm_pkg::ROOT_W-1:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = x;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[aprm_pkg::ROOT_W-1:0];
  endfunction

  // Accumulate one item; on block close update the meters and return 1
  function automatic bit advance_meter(input logic signed [aprm_pkg::SAMPLE_W-1:0] left,
                                       input logic signed [aprm_pkg::SAMPLE_W-1:0] right,
                                       input logic last, output reading_t rd);
    logic [aprm_pkg::SAMPLE_W-1:0] raw;
    logic [aprm_pkg::MAG_W-1:0]    mag;
    logic [63:0]                   sq;
    logic [63:0]                   n;
    logic [63:0]                   mean;
    logic [63:0]                   sms;
    bit                            clipped;
    clipped = 1'b0;
    rd      = '0;
    for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
      raw = (c == 0 || meter_cfg.mono) ? left : right;
      mag = raw[aprm_pkg::SAMPLE_W-1] ? ~raw + 1'b1 : raw;
      sq  = 64'(mag) * 64'(mag);
      if (mag > open_peak[c]) open_peak[c] = mag;
      // Saturate the sum of squares
      if (64'(open_sq_sum[c]) > 64'(aprm_pkg::SUM_MAX) - sq)
        open_sq_sum[c] = aprm_pkg::SUM_MAX;
      else
        open_sq_sum[c] = open_sq_sum[c] + aprm_pkg::SUM_W'(sq);
    end
    open_count = open_count + 1'b1;
    if (!last && open_count < aprm_pkg::MAX_BLOCK) return 1'b0;

    n = 64'(open_count);
    for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
      mean = (64'(open_sq_sum[c]) / n) >> aprm_pkg::MS_SHIFT;
      sms  = 64'(smoothed_ms[c]);
      if (open_peak[c] >= meter_cfg.clip_thr) clipped = 1'b1;
      // Rise instantly, otherwise release by the decay gain
      if (open_peak[c] > held_level[c]) held_level[c] = open_peak[c];
      else held_level[c] = aprm_pkg::MAG_W'((64'(held_level[c]) *
                           64'(meter_cfg.decay_gain)) >> aprm_pkg::FRAC_W);
      // One-pole step, truncated toward zero
      if (mean >= sms)
        sms = sms + (((mean - sms) * 64'(meter_cfg.rms_coef)) >> aprm_pkg::FRAC_W);
      else
        sms = sms - (((sms - mean) * 64'(meter_cfg.rms_coef)) >> aprm_pkg::FRAC_W);
      if (sms > 64'(aprm_pkg::SMS_MAX)) sms = 64'(aprm_pkg::SMS_MAX);
      smoothed_ms[c] = aprm_pkg::MS_W'(sms);
      open_peak[c]   = '0;
      open_sq_sum[c] = '0;
    end
    open_count = '0;

    if (clipped) clip_countdown_q = meter_cfg.clip_hold;
    else if (64'(clip_countdown_q) > n)
      clip_countdown_q = clip_countdown_q - aprm_pkg::HOLD_W'(n);
    else clip_countdown_q = '0;

    rd.peak_l = held_level[0];
    rd.peak_r = held_level[aprm_pkg::RIGHT_CH];
    rd.rms_l  = floor_sqrt(64'(smoothed_ms[0]) << aprm_pkg::MS_SHIFT);
    rd.rms_r  = floor_sqrt(64'(smoothed_ms[aprm_pkg::RIGHT_CH]) << aprm_pkg::MS_SHIFT);
    rd.clip   = (clip_countdown_q != 0);
    return 1'b1;
  endfunction

  function automatic logic signed [aprm_pkg::SAMPLE_W-1:0] pick_sample(input bit quiet);
    if (quiet) return aprm_pkg::SAMPLE_W'(int'($urandom_range(64)) - 32);
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return aprm_pkg::SAMPLE_W'(int'($urandom_range(4096)) - 2048);
      default: return aprm_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    $display("%0t ns: MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Offer one item, wait for acceptance, then predict its reading
  task automatic send_sample(input logic signed [aprm_pkg::SAMPLE_W-1:0] left,
                             input logic signed [aprm_pkg::SAMPLE_W-1:0] right,
                             input logic last, input bit typed = 1'b0,
                             input reading_t want = '0);
    reading_t rd;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_left  <= left;
    sample_ch.sample_right <= right;
    sample_ch.block_end    <= last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (advance_meter(left, right, last, rd)) pending_readings.push_back(typed ? want : rd);
    items_sent++;
  endtask

  task automatic send_block(input int len, input bit quiet);
    for (int k = 1; k <= len; k++) send_sample(pick_sample(quiet), pick_sample(quiet), k == len);
  endtask

  // Random blocks: mostly short, a few long, some near silent
  task automatic run_phase(input int n_items);
    int target;
    int len;
    bit quiet;
    target = items_sent + n_items;
    while (items_sent < target) begin
      len   = ($urandom_range(15) == 0) ? $urandom_range(200, 40) : $urandom_range(12, 1);
      quiet = ($urandom_range(5) == 0);
      send_block(len, quiet);
    end
  endtask

  // Drop valid and let every outstanding reading drain
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aprm_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [aprm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      aprm_pkg::CFG_DECAY_GAIN: meter_cfg.decay_gain = data[aprm_pkg::GAIN_W-1:0];
      aprm_pkg::CFG_RMS_COEF:   meter_cfg.rms_coef   = data[aprm_pkg::COEF_W-1:0];
      aprm_pkg::CFG_CLIP_THR:   meter_cfg.clip_thr   = data[aprm_pkg::THR_W-1:0];
      aprm_pkg::CFG_CLIP_HOLD:  meter_cfg.clip_hold  = data[aprm_pkg::HOLD_W-1:0];
      aprm_pkg::CFG_MONO:       meter_cfg.mono       = data[0];
      default: ;
    endcase
  endtask

  // Write all registers; optionally hit the unused indexes afterwards
  task automatic apply_setting(input int unsigned gain, input int unsigned coef,
                               input int unsigned thr, input int unsigned hold,
                               input int unsigned mono, input bit stray);
    write_reg(aprm_pkg::CFG_DECAY_GAIN, aprm_pkg::CFG_DATA_W'(gain));
    write_reg(aprm_pkg::CFG_RMS_COEF, aprm_pkg::CFG_DATA_W'(coef));
    write_reg(aprm_pkg::CFG_CLIP_THR, aprm_pkg::CFG_DATA_W'(thr));
    write_reg(aprm_pkg::CFG_CLIP_HOLD, aprm_pkg::CFG_DATA_W'(hold));
    write_reg(aprm_pkg::CFG_MONO, aprm_pkg::CFG_DATA_W'(mono));
    if (stray) begin
      for (int a = int'(aprm_pkg::CFG_MONO) + 1; a < (1 << aprm_pkg::CFG_ADDR_W); a++)
        write_reg(aprm_pkg::CFG_ADDR_W'(a), aprm_pkg::CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Check each accepted reading against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && reading_ch.valid && reading_ch.ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending, peak_left", 0, reading_ch.peak_left);
      end else begin
        if (reading_ch.peak_left !== pending_readings[0].peak_l)
          report_mismatch("peak_left", pending_readings[0].peak_l, reading_ch.peak_left);
        if (reading_ch.peak_right !== pending_readings[0].peak_r)
          report_mismatch("peak_right", pending_readings[0].peak_r, reading_ch.peak_right);
        if (reading_ch.rms_left !== pending_readings[0].rms_l)
          report_mismatch("rms_left", pending_readings[0].rms_l, reading_ch.rms_left);
        if (reading_ch.rms_right !== pending_readings[0].rms_r)
          report_mismatch("rms_right", pending_readings[0].rms_r, reading_ch.rms_right);
        if (reading_ch.clip_active !== pending_readings[0].clip)
          report_mismatch("clip_active", pending_readings[0].clip, reading_ch.clip_active);
        void'(pending_readings.pop_front());
      end
    end
  end

  // Output ready: random stalls, plus a long hold when requested
  initial begin
    int hold_len;
    reading_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req != 0) begin
        hold_len    = rx_hold_req;
        rx_hold_req = 0;
        reading_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      reading_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int waited;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_addr               <= '0;
    cfg_wdata              <= '0;
    sample_ch.valid        <= 1'b0;
    sample_ch.sample_left  <= '0;
    sample_ch.sample_right <= '0;
    sample_ch.block_end    <= 1'b0;
    meter_cfg = '{aprm_pkg::DECAY_GAIN_RST, aprm_pkg::RMS_COEF_RST, aprm_pkg::CLIP_THR_RST,
                  aprm_pkg::CLIP_HOLD_RST, 1'b0};
    for (int c = 0; c < aprm_pkg::CHANNELS; c++) begin
      held_level[c]  = '0;
      smoothed_ms[c] = '0;
      open_peak[c]   = '0;
      open_sq_sum[c] = '0;
    end
    open_count       = '0;
    clip_countdown_q = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver mostly stalled
    tx_idle_pct = 10;
    rx_idle_pct = 83;
    for (int i = 0; i < DIR_ROWS; i++)
      send_sample(DIRECTED[i].left, DIRECTED[i].right, DIRECTED[i].last,
                  DIRECTED[i].typed, DIRECTED[i].want);
    run_phase(PHASE_ITEMS);

    // Zero threshold clips every block; zero hold keeps the flag low; mono
    wait_idle();
    apply_setting(0, 65535, 0, 0, 1, 1'b1);
    run_phase(PHASE_ITEMS);

    // Swap idling: sender mostly idle, receiver mostly ready
    tx_idle_pct = 83;
    rx_idle_pct = 10;
    wait_idle();
    apply_setting(65535, 0, 8388609, 1048575, 0, 1'b0);
    run_phase(PHASE_ITEMS);

    wait_idle();
    apply_setting($urandom_range(65535), $urandom_range(65535), 24'hFFFFFF,
                  $urandom_range(1048575), $urandom_range(1), 1'b1);
    run_phase(PHASE_ITEMS);

    // No idling; stall the output long enough to back up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_idle();
    apply_setting($urandom_range(65535), $urandom_range(65535),
                  $urandom_range(8388608, 6000000), $urandom_range(300), 0, 1'b0);
    rx_hold_req = RX_HOLD;
    run_phase(PHASE_ITEMS);

    // Pause the sender mid-phase until every reading is back
    wait_idle();
    apply_setting($urandom_range(65535), $urandom_range(65535), $urandom_range(8388608),
                  $urandom_range(1048575), $urandom_range(1), 1'b1);
    run_phase(PHASE_ITEMS / 2);
    wait_idle();
    run_phase(PHASE_ITEMS / 2);

    // Long block at full scale
    wait_idle();
    apply_setting($urandom_range(65535), $urandom_range(65535), $urandom_range(8388608),
                  $urandom_range(20000), 0, 1'b0);
    for (int k = 0; k < FULL_ITEMS; k++) send_sample(S_MIN, S_MIN, 1'b0);
    send_block(3, 1'b0);

    // Drain and settle
    sample_ch.valid <= 1'b0;
    waited = 0;
    while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_readings.size() != 0) begin
      report_mismatch("reading never arrived, peak_left", pending_readings[0].peak_l, 0);
      void'(pending_readings.pop_front());
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/aprm_pkg.sv
design/aprm_stream_if.sv
design/aprm_front.sv
design/aprm_queue.sv
design/aprm_back.sv
design/audio_peak_rms_clip_meter.sv
sim/audio_peak_rms_clip_meter_tb.sv
